### rtl/core/jtsc_pkg.sv
// ----------------------------------------------------------------------------
// jtsc_pkg - shared types and codes of the json token structure checker
// Token, event, status and parser state codes, plus the beat payload types.
// ----------------------------------------------------------------------------
package jtsc_pkg;

    // token kinds from the tokenizer
    localparam logic [3:0] TK_STRING = 4'd0;
    localparam logic [3:0] TK_TRUE   = 4'd1;
    localparam logic [3:0] TK_FALSE  = 4'd2;
    localparam logic [3:0] TK_NULL   = 4'd3;
    localparam logic [3:0] TK_NUMBER = 4'd4;
    localparam logic [3:0] TK_LBRACK = 4'd5;
    localparam logic [3:0] TK_RBRACK = 4'd6;
    localparam logic [3:0] TK_LBRACE = 4'd7;
    localparam logic [3:0] TK_RBRACE = 4'd8;
    localparam logic [3:0] TK_COLON  = 4'd9;
    localparam logic [3:0] TK_COMMA  = 4'd10;
    localparam logic [3:0] TK_END    = 4'd11;

    // structural events
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_OBJ    = 3'd1;
    localparam logic [2:0] EV_ARR    = 3'd2;
    localparam logic [2:0] EV_CLOSE  = 3'd3;
    localparam logic [2:0] EV_KEY    = 3'd4;
    localparam logic [2:0] EV_SCALAR = 3'd5;
    localparam logic [2:0] EV_END    = 3'd6;

    // result status
    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;

    // parser states
    localparam logic [3:0] PS_VALUE     = 4'd0;
    localparam logic [3:0] PS_KEY_CLOSE = 4'd1;
    localparam logic [3:0] PS_COLON     = 4'd2;
    localparam logic [3:0] PS_OBJ_VALUE = 4'd3;
    localparam logic [3:0] PS_OBJ_NEXT  = 4'd4;
    localparam logic [3:0] PS_ARR_VALUE = 4'd5;
    localparam logic [3:0] PS_ARR_NEXT  = 4'd6;
    localparam logic [3:0] PS_ERROR     = 4'd7;
    localparam logic [3:0] PS_DONE      = 4'd8;

    // return stack entries
    localparam logic [1:0] RET_DONE     = 2'd0;
    localparam logic [1:0] RET_OBJ_NEXT = 2'd1;
    localparam logic [1:0] RET_ARR_NEXT = 2'd2;

    // input beat
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] line_number;
        logic        restart;
    } tok_in_t;

    // result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  event_res;
        logic [9:0]  nesting_depth;
        logic [15:0] error_line;
    } res_out_t;

endpackage

### rtl/core/jtsc_ram.sv
// ----------------------------------------------------------------------------
// jtsc_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jtsc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/json_token_structure_checker_unit.sv
// ----------------------------------------------------------------------------
// json_token_structure_checker_unit - pushdown checker for JSON token streams
// Runs the JSON grammar over tokens and reports status, event and depth.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid / in_stall / in_data carries one token per beat.
//   Output channel out_valid / out_stall / out_data gives one result per token.
//   A beat moves at a rising edge with valid high and stall low.
//   cfg_wr_en / cfg_wr_data write require_end_after_value; write it only idle.
// Pipeline and throughput
//   A token lands in the input register, then one pass of parser logic feeds
//   the result register, which takes it once the result side is not stalled.
//   One token per cycle while out_stall is low; the return stack is a RAM with
//   registered read whose next entry below the top is fetched every cycle, with
//   a bypass register covering the entry written by the previous push.
// Reset
//   rst_n clears both stages, the parser state (value expected), the stack
//   depth (one entry, the done marker) and the config register. Stack RAM
//   contents need no clearing. A token with restart set re-initialises too.
// Stall
//   While out_stall holds a result, the input register still takes one more
//   token; in_stall rises only when both stages are full and out_stall is high.
// ----------------------------------------------------------------------------
module json_token_structure_checker_unit
    import jtsc_pkg::*;
#(
    parameter int MAX_DEPTH = 512
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,
    input  logic     in_valid,
    output logic     in_stall,
    input  tok_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output res_out_t out_data
);

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int AW    = $clog2(MAX_DEPTH);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    logic             req_end_reg;
    logic             item_valid_reg;
    tok_in_t          item_reg;
    logic             out_valid_reg;
    res_out_t         out_data_reg;
    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       tos_reg;
    logic [1:0]       tos_next;
    logic [15:0]      err_line_reg;
    logic [15:0]      err_line_next;
    logic             byp_reg;
    logic [1:0]       byp_data_reg;

    logic             advance;
    logic [3:0]       st_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic [1:0]       tos_eff;
    logic [15:0]      err_line_eff;
    logic [1:0]       below;
    logic [1:0]       rd_data;
    logic [CNT_W-1:0] rd_cnt;
    logic [CNT_W-1:0] rd_pos;
    logic [CNT_W-1:0] wr_pos;
    logic [CNT_W+9:0] depth_wide;

    logic             do_push;
    logic             do_pop;
    logic [1:0]       push_ret;
    logic             bad;
    logic [2:0]       ev;
    logic             scalar;
    logic [3:0]       tk;
    logic [3:0]       pop_state;
    logic             stack_full;
    res_out_t         res;

    // stage control
    assign advance   = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_end_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            req_end_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
    end

    // state seen by this token, after an optional restart
    always_comb
    begin
        if (item_reg.restart)
        begin
            st_eff       = PS_VALUE;
            cnt_eff      = ONE_CNT;
            tos_eff      = RET_DONE;
            err_line_eff = 16'd0;
        end
        else
        begin
            st_eff       = state_reg;
            cnt_eff      = count_reg;
            tos_eff      = tos_reg;
            err_line_eff = err_line_reg;
        end
    end

    // entry just below the top of the stack
    assign below = byp_reg ? byp_data_reg : rd_data;

    assign tk         = item_reg.token_kind;
    assign scalar     = (tk <= TK_NUMBER);
    assign stack_full = ((cnt_eff + ONE_CNT) == MAX_CNT);

    // return entry to parser state
    always_comb
    begin
        unique case (tos_eff)
            RET_OBJ_NEXT: pop_state = PS_OBJ_NEXT;
            RET_ARR_NEXT: pop_state = PS_ARR_NEXT;
            default:      pop_state = PS_DONE;
        endcase
    end

    // grammar transition
    always_comb
    begin
        state_next = st_eff;
        ev         = EV_NONE;
        bad        = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        push_ret   = (st_eff == PS_OBJ_VALUE) ? RET_OBJ_NEXT : RET_ARR_NEXT;
        unique case (st_eff) inside
            PS_VALUE:
            begin
                if (tk == TK_LBRACK)
                begin
                    ev         = EV_ARR;
                    state_next = PS_ARR_VALUE;
                end
                else if (tk == TK_LBRACE)
                begin
                    ev         = EV_OBJ;
                    state_next = PS_KEY_CLOSE;
                end
                else if (scalar)
                begin
                    ev     = EV_SCALAR;
                    do_pop = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PS_KEY_CLOSE:
            begin
                if (tk == TK_RBRACE)
                begin
                    ev     = EV_CLOSE;
                    do_pop = 1'b1;
                end
                else if (tk == TK_STRING)
                begin
                    ev         = EV_KEY;
                    state_next = PS_COLON;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PS_COLON:
            begin
                if (tk == TK_COLON)
                begin
                    state_next = PS_OBJ_VALUE;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PS_OBJ_VALUE, PS_ARR_VALUE:
            begin
                if (st_eff == PS_ARR_VALUE && tk == TK_RBRACK)
                begin
                    ev     = EV_CLOSE;
                    do_pop = 1'b1;
                end
                else if (scalar)
                begin
                    ev         = EV_SCALAR;
                    state_next = (st_eff == PS_OBJ_VALUE) ? PS_OBJ_NEXT : PS_ARR_NEXT;
                end
                else if (tk == TK_LBRACK || tk == TK_LBRACE)
                begin
                    state_next = (tk == TK_LBRACK) ? PS_ARR_VALUE : PS_KEY_CLOSE;
                    if (cnt_eff >= MAX_CNT)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        do_push = 1'b1;
                        if (stack_full)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            ev = (tk == TK_LBRACK) ? EV_ARR : EV_OBJ;
                        end
                    end
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PS_OBJ_NEXT, PS_ARR_NEXT:
            begin
                if (tk == TK_COMMA)
                begin
                    state_next = (st_eff == PS_OBJ_NEXT) ? PS_KEY_CLOSE : PS_ARR_VALUE;
                end
                else if ((st_eff == PS_OBJ_NEXT && tk == TK_RBRACE)
                      || (st_eff == PS_ARR_NEXT && tk == TK_RBRACK))
                begin
                    ev     = EV_CLOSE;
                    do_pop = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            PS_DONE:
            begin
                if (tk == TK_END)
                begin
                    ev = EV_END;
                end
                else if (req_end_reg)
                begin
                    bad = 1'b1;
                end
            end
            default:
            begin
                state_next = PS_ERROR;
            end
        endcase

        // a pop on an empty stack only marks completion
        if (do_pop)
        begin
            state_next = (cnt_eff == '0) ? PS_DONE : pop_state;
        end

        if (bad)
        begin
            state_next = PS_ERROR;
            ev         = EV_NONE;
        end
    end

    // stack pointer, top of stack and held error line
    always_comb
    begin
        count_next = cnt_eff;
        tos_next   = tos_eff;
        if (do_push)
        begin
            count_next = cnt_eff + ONE_CNT;
            tos_next   = push_ret;
        end
        else if (do_pop && cnt_eff != '0)
        begin
            count_next = cnt_eff - ONE_CNT;
            tos_next   = below;
        end
        err_line_next = bad ? item_reg.line_number : err_line_eff;
    end

    // result assembly
    assign depth_wide = {10'd0, count_next};

    always_comb
    begin
        res.event_res     = ev;
        res.nesting_depth = depth_wide[9:0];
        res.error_line    = (state_next == PS_ERROR) ? err_line_next : 16'd0;
        if (state_next == PS_ERROR)
        begin
            res.status = ST_FAULT;
        end
        else if (state_next == PS_DONE)
        begin
            res.status = ST_DONE;
        end
        else
        begin
            res.status = ST_RUNNING;
        end
    end

    // return stack ram, entries below the top
    assign wr_pos = cnt_eff - ONE_CNT;
    assign rd_cnt = advance ? count_next : count_reg;
    assign rd_pos = rd_cnt - TWO_CNT;

    jtsc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (advance && do_push),
        .wr_addr (wr_pos[AW-1:0]),
        .wr_data (tos_eff),
        .rd_addr (rd_pos[AW-1:0]),
        .rd_data (rd_data)
    );

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PS_VALUE;
            count_reg    <= ONE_CNT;
            tos_reg      <= RET_DONE;
            err_line_reg <= 16'd0;
            byp_reg      <= 1'b0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            tos_reg      <= tos_next;
            err_line_reg <= err_line_next;
            byp_reg      <= do_push;
        end
    end

    // bypass for the entry written by a push
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byp_data_reg <= tos_eff;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    // checks
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("stack count above maximum depth");

    a_status_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((out_data_reg.status == ST_DONE) == (state_reg == PS_DONE))
                 && ((out_data_reg.status == ST_FAULT) == (state_reg == PS_ERROR)))
        else $error("result status disagrees with parser state");

    a_error_holds_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg == PS_ERROR && !item_reg.restart)
        |=> (count_reg == $past(count_reg)) && (err_line_reg == $past(err_line_reg)))
        else $error("stack or error line moved while in error");

    a_error_line_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_FAULT)
        |-> (out_data_reg.error_line == 16'd0))
        else $error("error line reported without error status");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the json token structure checker
// Feeds directed and randomly built token streams (well formed documents,
// damaged ones, deep nesting up to stack overflow) through the unit under
// random idling on both channels, predicts every result beat with a
// grammar tracker of its own and compares the results field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import jtsc_pkg::*;

    localparam int STACK_DEPTH  = 512;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 60;

    // token codes the package leaves unnamed
    localparam logic [3:0] TK_OTHER   = 4'd12;
    localparam logic [3:0] TK_UNKNOWN = 4'd13;
    localparam logic [3:0] TK_TOP     = 4'd15;

    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     cfg_wr_en   = 1'b0;
    logic     cfg_wr_data = 1'b0;
    logic     in_valid    = 1'b0;
    logic     in_stall;
    tok_in_t  in_data     = '0;
    logic     out_valid;
    logic     out_stall   = 1'b0;
    res_out_t out_data;

    json_token_structure_checker_unit #(
        .MAX_DEPTH (STACK_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tok_in_t     pending_tokens[$];
    tok_in_t     doc[$];
    res_out_t    expected_results[$];
    res_out_t    want_res;
    int          tokens_queued  = 0;
    int          beats_in       = 0;
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          hold_left      = 0;
    bit          held_once      = 1'b0;
    int unsigned cycle_count    = 0;

    // grammar tracker state
    logic [3:0]  parse_st;
    logic [1:0]  return_st [STACK_DEPTH];
    int          frame_count;
    logic [15:0] first_err_line;
    logic        need_end;

    function automatic void clear_parser();
        return_st[0]   = RET_DONE;
        frame_count    = 1;
        parse_st       = PS_VALUE;
        first_err_line = '0;
    endfunction

    function automatic void pop_frame();
        if (frame_count == 0)
            parse_st = PS_DONE;
        else
        begin
            frame_count--;
            case (return_st[frame_count])
                RET_OBJ_NEXT: parse_st = PS_OBJ_NEXT;
                RET_ARR_NEXT: parse_st = PS_ARR_NEXT;
                default:      parse_st = PS_DONE;
            endcase
        end
    endfunction

    // false once the stack has become full
    function automatic bit push_frame(logic [1:0] ret);
        if (frame_count >= STACK_DEPTH)
            return 1'b0;
        return_st[frame_count] = ret;
        frame_count++;
        return frame_count < STACK_DEPTH;
    endfunction

    // advances the tracker by one token and gives the result it should produce
    function automatic res_out_t parse_token(tok_in_t t);
        res_out_t   r;
        logic [2:0] ev;
        logic [1:0] ret;
        logic       bad;
        logic       scalar;
        logic       opener;
        ev     = EV_NONE;
        bad    = 1'b0;
        scalar = (t.token_kind <= TK_NUMBER);
        opener = (t.token_kind == TK_LBRACK) || (t.token_kind == TK_LBRACE);
        if (t.restart)
            clear_parser();
        case (parse_st) inside
            PS_VALUE:
                if (t.token_kind == TK_LBRACK)
                begin
                    ev       = EV_ARR;
                    parse_st = PS_ARR_VALUE;
                end
                else if (t.token_kind == TK_LBRACE)
                begin
                    ev       = EV_OBJ;
                    parse_st = PS_KEY_CLOSE;
                end
                else if (scalar)
                begin
                    ev = EV_SCALAR;
                    pop_frame();
                end
                else
                    bad = 1'b1;
            PS_KEY_CLOSE:
                if (t.token_kind == TK_RBRACE)
                begin
                    ev = EV_CLOSE;
                    pop_frame();
                end
                else if (t.token_kind == TK_STRING)
                begin
                    ev       = EV_KEY;
                    parse_st = PS_COLON;
                end
                else
                    bad = 1'b1;
            PS_COLON:
                if (t.token_kind == TK_COLON)
                    parse_st = PS_OBJ_VALUE;
                else
                    bad = 1'b1;
            PS_OBJ_VALUE, PS_ARR_VALUE:
                if (parse_st == PS_ARR_VALUE && t.token_kind == TK_RBRACK)
                begin
                    ev = EV_CLOSE;
                    pop_frame();
                end
                else if (scalar)
                begin
                    ev       = EV_SCALAR;
                    parse_st = (parse_st == PS_OBJ_VALUE) ? PS_OBJ_NEXT : PS_ARR_NEXT;
                end
                else if (opener)
                begin
                    ret      = (parse_st == PS_OBJ_VALUE) ? RET_OBJ_NEXT : RET_ARR_NEXT;
                    parse_st = (t.token_kind == TK_LBRACK) ? PS_ARR_VALUE : PS_KEY_CLOSE;
                    if (push_frame(ret))
                        ev = (t.token_kind == TK_LBRACK) ? EV_ARR : EV_OBJ;
                    else
                        bad = 1'b1;
                end
                else
                    bad = 1'b1;
            PS_OBJ_NEXT:
                if (t.token_kind == TK_COMMA)
                    parse_st = PS_KEY_CLOSE;
                else if (t.token_kind == TK_RBRACE)
                begin
                    ev = EV_CLOSE;
                    pop_frame();
                end
                else
                    bad = 1'b1;
            PS_ARR_NEXT:
                if (t.token_kind == TK_COMMA)
                    parse_st = PS_ARR_VALUE;
                else if (t.token_kind == TK_RBRACK)
                begin
                    ev = EV_CLOSE;
                    pop_frame();
                end
                else
                    bad = 1'b1;
            PS_DONE:
                if (t.token_kind == TK_END)
                    ev = EV_END;
                else if (need_end)
                    bad = 1'b1;
            default:
                parse_st = PS_ERROR;
        endcase
        if (bad)
        begin
            parse_st       = PS_ERROR;
            first_err_line = t.line_number;
            ev             = EV_NONE;
        end
        if (parse_st == PS_ERROR)
            r.status = ST_FAULT;
        else if (parse_st == PS_DONE)
            r.status = ST_DONE;
        else
            r.status = ST_RUNNING;
        r.event_res     = ev;
        r.nesting_depth = 10'(frame_count);
        r.error_line    = (parse_st == PS_ERROR) ? first_err_line : 16'd0;
        return r;
    endfunction

    // token building
    function automatic void add_token(logic [3:0] kind, logic rs);
        tok_in_t t;
        t.token_kind  = kind;
        t.line_number = 16'($urandom_range(0, 65535));
        t.restart     = rs;
        doc.push_back(t);
    endfunction

    function automatic void add_scalar();
        add_token(4'($urandom_range(TK_STRING, TK_NUMBER)), 1'b0);
    endfunction

    // random well-formed value, containers of up to three members
    function automatic void gen_value(int level, int max_level);
        int n;
        int pick;
        pick = $urandom_range(0, 3);
        if (level >= max_level || pick < 2)
            add_scalar();
        else if (pick == 2)
        begin
            add_token(TK_LBRACK, 1'b0);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_token(TK_COMMA, 1'b0);
                gen_value(level + 1, max_level);
            end
            add_token(TK_RBRACK, 1'b0);
        end
        else
        begin
            add_token(TK_LBRACE, 1'b0);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_token(TK_COMMA, 1'b0);
                add_token(TK_STRING, 1'b0);
                add_token(TK_COLON, 1'b0);
                gen_value(level + 1, max_level);
            end
            add_token(TK_RBRACE, 1'b0);
        end
    endfunction

    function automatic void flush_doc();
        foreach (doc[i])
        begin
            pending_tokens.push_back(doc[i]);
            tokens_queued++;
        end
        doc.delete();
    endfunction

    // one document, sometimes damaged, truncated or followed by noise
    function automatic void queue_random_doc();
        int pick;
        int cut;
        gen_value(0, $urandom_range(0, 5));
        if ($urandom_range(0, 99) < 70)
            add_token(TK_END, 1'b0);
        repeat ($urandom_range(0, 1))
            add_token(4'($urandom_range(TK_STRING, TK_TOP)), 1'b0);
        doc[0].restart = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            doc[$urandom_range(0, doc.size() - 1)].token_kind =
                4'($urandom_range(TK_STRING, TK_TOP));
        else if (pick < 22)
            doc[$urandom_range(0, doc.size() - 1)].restart = 1'b1;
        else if (pick < 30)
        begin
            cut = $urandom_range(1, doc.size());
            while (doc.size() > cut)
                doc.delete(doc.size() - 1);
        end
        flush_doc();
    endfunction

    // deep nesting, mostly arrays; closed again unless it overflows the stack
    function automatic void queue_nest_doc(int opens);
        bit in_obj[$];
        bit first;
        for (int i = 0; i < opens; i++)
        begin
            if (in_obj.size() > 0 && in_obj[$])
            begin
                add_token(TK_STRING, 1'b0);
                add_token(TK_COLON, 1'b0);
            end
            if ($urandom_range(0, 9) < 8)
            begin
                add_token(TK_LBRACK, 1'b0);
                in_obj.push_back(1'b0);
            end
            else
            begin
                add_token(TK_LBRACE, 1'b0);
                in_obj.push_back(1'b1);
            end
        end
        first = 1'b1;
        if (opens < STACK_DEPTH)
            while (in_obj.size() > 0)
            begin
                // after a nested close the parent takes further members
                if (!first && $urandom_range(0, 2) == 0)
                begin
                    add_token(TK_COMMA, 1'b0);
                    if (in_obj[$])
                    begin
                        add_token(TK_STRING, 1'b0);
                        add_token(TK_COLON, 1'b0);
                    end
                    add_scalar();
                end
                add_token(in_obj[$] ? TK_RBRACE : TK_RBRACK, 1'b0);
                in_obj.delete(in_obj.size() - 1);
                first = 1'b0;
            end
        add_token(TK_END, 1'b0);
        add_scalar();
        doc[0].restart = 1'b1;
        flush_doc();
    endfunction

    task automatic write_require_end(logic v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        need_end     = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained();
        while (beats_in != tokens_queued || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, logic req_end, int n_tokens,
                             int nest_opens);
        int start;
        int nest_left;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_require_end(req_end);
        start     = tokens_queued;
        nest_left = nest_opens;
        while (tokens_queued - start < n_tokens || nest_left > 0)
        begin
            if (nest_left > 0 && tokens_queued - start >= n_tokens / 2)
            begin
                queue_nest_doc(nest_left);
                nest_left = 0;
            end
            else
                queue_random_doc();
        end
        wait_drained();
    endtask

    // token driver: next beat once the current one is taken or none is offered
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            beats_in <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(parse_token(in_data));
                beats_in <= beats_in + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_tokens.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_tokens.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side stall, with one long hold so the unit backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left  = 0;
            held_once  = 1'b0;
        end
        else
        begin
            if (hold_left > 0)
                hold_left--;
            else if (!held_once && beats_in >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                held_once = 1'b1;
            end
            out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic void check_result(bit have, res_out_t want, res_out_t got);
        if (!have || want.status !== got.status || want.event_res !== got.event_res
            || want.nesting_depth !== got.nesting_depth || want.error_line !== got.error_line)
        begin
            if (mismatch_count < MAX_REPORTS)
            begin
                if (!have)
                    $display({"result beat with nothing expected: ",
                              "status %0d event %0d depth %0d line %0d"},
                             got.status, got.event_res, got.nesting_depth, got.error_line);
                else
                    $display({"result mismatch (exp/got): ",
                              "status %0d/%0d event %0d/%0d depth %0d/%0d line %0d/%0d"},
                             want.status, got.status, want.event_res, got.event_res,
                             want.nesting_depth, got.nesting_depth,
                             want.error_line, got.error_line);
            end
            mismatch_count++;
        end
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                check_result(1'b0, '0, out_data);
            else
            begin
                want_res = expected_results.pop_front();
                check_result(1'b1, want_res, out_data);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        clear_parser();
        need_end = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every token kind, nesting, completion with end optional
        send_idle_pct = 38;
        recv_idle_pct = 68;
        write_require_end(1'b0);
        add_token(TK_LBRACE, 1'b1);
        doc[$].line_number = 16'h0000;
        add_token(TK_STRING, 1'b0);
        add_token(TK_COLON, 1'b0);
        add_token(TK_LBRACK, 1'b0);
        add_token(TK_TRUE, 1'b0);
        add_token(TK_COMMA, 1'b0);
        add_token(TK_FALSE, 1'b0);
        add_token(TK_COMMA, 1'b0);
        add_token(TK_NULL, 1'b0);
        add_token(TK_COMMA, 1'b0);
        add_token(TK_NUMBER, 1'b0);
        add_token(TK_COMMA, 1'b0);
        add_token(TK_LBRACE, 1'b0);
        add_token(TK_RBRACE, 1'b0);
        add_token(TK_RBRACK, 1'b0);
        add_token(TK_RBRACE, 1'b0);
        // ignored after completion, then the end itself
        add_token(TK_STRING, 1'b0);
        add_token(TK_END, 1'b0);
        // early end, then sticky error on the top line number
        add_token(TK_END, 1'b1);
        doc[$].line_number = 16'hFFFF;
        add_token(TK_LBRACK, 1'b0);
        // never-accepted and unknown codes
        add_token(TK_OTHER, 1'b1);
        add_token(TK_TOP, 1'b1);
        flush_doc();
        wait_drained();

        // directed: end required after a complete value
        write_require_end(1'b1);
        add_token(TK_NUMBER, 1'b1);
        add_token(TK_COMMA, 1'b0);
        add_token(TK_RBRACK, 1'b1);
        add_token(TK_LBRACK, 1'b1);
        add_token(TK_RBRACK, 1'b0);
        add_token(TK_END, 1'b0);
        add_token(TK_UNKNOWN, 1'b1);
        flush_doc();
        wait_drained();

        // random: sender light / receiver heavy, then swapped, then flat out
        run_phase(38, 68, 1'b1, 100, 0);
        run_phase(68, 38, 1'b0, 100, $urandom_range(20, 40));
        run_phase(0, 0, 1'b1, 80, STACK_DEPTH);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
